/* rtl/boxtrk_pkg.sv */
`timescale 1ns / 1ps
package boxtrk_pkg;
	localparam int TIME_BITS = 32;
	localparam int ID_BITS = 32;
	localparam int RATIO_BITS = 7;
	localparam int HOLD_BITS = 16;
	localparam int CFG_DATA_BITS = 16;
	localparam int CFG_IDX_BITS = 1;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_RATIO = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HOLD = 1'd1;
	localparam logic [RATIO_BITS-1:0] RATIO_RESET = 7'd50;
	localparam logic [HOLD_BITS-1:0] HOLD_RESET = 16'd5;
	localparam logic [6:0] PERCENT_SCALE = 7'd100;
endpackage

/* rtl/boxtrk_if.sv */
`timescale 1ns / 1ps
interface boxtrk_in_if #(parameter int COORD_BITS = 12);
	logic valid;
	logic ready;
	logic [31:0] frame_time;
	logic [COORD_BITS-1:0] left_x;
	logic [COORD_BITS-1:0] top_y;
	logic [COORD_BITS-1:0] right_x;
	logic [COORD_BITS-1:0] bottom_y;
	logic frame_end;
	modport source (output valid, frame_time, left_x, top_y, right_x, bottom_y, frame_end,
		input ready);
	modport sink (input valid, frame_time, left_x, top_y, right_x, bottom_y, frame_end,
		output ready);
endinterface

interface boxtrk_out_if;
	logic valid;
	logic ready;
	logic [31:0] object_id;
	logic is_new;
	logic table_full;
	logic [31:0] object_age;
	modport source (output valid, object_id, is_new, table_full, object_age, input ready);
	modport sink (input valid, object_id, is_new, table_full, object_age, output ready);
endinterface

/* rtl/boxtrk_mul.sv */
`timescale 1ns / 1ps
// shared multiplier with registered product
module boxtrk_mul
	import boxtrk_pkg::*;
#(
	parameter int W = 32
) (
	input logic clk,
	input logic [W-1:0] a,
	input logic [W-1:0] b,
	output logic [2*W-1:0] p
);
	// one product a cycle
	always_ff @(posedge clk) begin
		p <= a * b;
	end
endmodule

/* rtl/bbox_overlap_object_tracker.sv */
`timescale 1ns / 1ps
// channel | dir | payload
// in_ch   | in  | frame_time, left_x, top_y, right_x, bottom_y, frame_end
// out_ch  | out | object_id, is_new, table_full, object_age
// cfg     | in  | cfg_we, cfg_idx, cfg_data
// each item: area of the box, then one pass per valid entry through the shared
//   multiplier, one more scan step when the table is not full, and on frame_end a
//   compaction over all MAX_OBJECTS entries, one entry per cycle
// reset clears the valid bits, the id counter and the registers, and loads the ratio and hold defaults
// not ready while an item is in work or its result waits to be taken
module bbox_overlap_object_tracker
	import boxtrk_pkg::*;
#(
	parameter int MAX_OBJECTS = 16,
	parameter int COORD_BITS = 12
) (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [CFG_IDX_BITS-1:0] cfg_idx,
	input logic [CFG_DATA_BITS-1:0] cfg_data,
	boxtrk_in_if.sink in_ch,
	boxtrk_out_if.source out_ch
);
	localparam int IW = $clog2(MAX_OBJECTS);
	localparam int CW = $clog2(MAX_OBJECTS + 1);
	localparam int AW = 2 * COORD_BITS;
	localparam int MW = 32;

	typedef enum logic [3:0] {
		S_IDLE, S_AREA, S_SCAN, S_OAREA, S_THR1, S_THR2, S_BEST1, S_BEST2,
		S_DECIDE, S_APPLY, S_AGE, S_OUT
	} state_t;
	typedef logic [4*COORD_BITS-1:0] box_t;

	state_t st_q;
	logic [RATIO_BITS-1:0] ratio_q;
	logic [HOLD_BITS-1:0] hold_q;
	logic [MAX_OBJECTS-1:0] vld_q;
	box_t box_mem [MAX_OBJECTS];
	logic [TIME_BITS-1:0] seen_mem [MAX_OBJECTS];
	logic [TIME_BITS-1:0] age_mem [MAX_OBJECTS];
	logic [ID_BITS-1:0] id_mem [MAX_OBJECTS];
	logic [ID_BITS-1:0] next_id_q;

	logic [TIME_BITS-1:0] now_q;
	box_t box_q;
	logic fend_q;
	logic [AW-1:0] barea_q, s_q, l_q, bs_q, bl_q;
	logic best_ok_q;
	logic [IW-1:0] best_q, idx_q, wr_q;
	logic [CW-1:0] used_q;
	logic [2*MW-1:0] tmp_q;
	logic meet_q;

	logic [ID_BITS-1:0] out_id_q;
	logic [TIME_BITS-1:0] out_age_q;
	logic out_new_q, out_full_q, out_v_q;

	logic [MW-1:0] ma, mb;
	logic [2*MW-1:0] mp;

	boxtrk_mul #(.W(MW)) u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

	// field access
	function automatic logic [COORD_BITS-1:0] fld(box_t b, int k);
		return b[k*COORD_BITS +: COORD_BITS];
	endfunction

	box_t ebox;
	logic [COORD_BITS-1:0] il, it, ir, ib, ew, eh, bw, bh;
	assign ebox = box_mem[idx_q];
	assign il = (fld(ebox,0) > fld(box_q,0)) ? fld(ebox,0) : fld(box_q,0);
	assign it = (fld(ebox,1) > fld(box_q,1)) ? fld(ebox,1) : fld(box_q,1);
	assign ir = (fld(ebox,2) < fld(box_q,2)) ? fld(ebox,2) : fld(box_q,2);
	assign ib = (fld(ebox,3) < fld(box_q,3)) ? fld(ebox,3) : fld(box_q,3);
	assign ew = (fld(ebox,2) > fld(ebox,0)) ? fld(ebox,2) - fld(ebox,0) : '0;
	assign eh = (fld(ebox,3) > fld(ebox,1)) ? fld(ebox,3) - fld(ebox,1) : '0;
	assign bw = (fld(box_q,2) > fld(box_q,0)) ? fld(box_q,2) - fld(box_q,0) : '0;
	assign bh = (fld(box_q,3) > fld(box_q,1)) ? fld(box_q,3) - fld(box_q,1) : '0;

	// multiplier operand select
	always_comb begin
		ma = '0;
		mb = '0;
		case (st_q)
			S_AREA: begin ma = MW'(bw); mb = MW'(bh); end
			S_SCAN: begin ma = MW'(ew); mb = MW'(eh); end
			S_THR1: begin ma = MW'(s_q); mb = MW'(PERCENT_SCALE); end
			S_THR2: begin ma = MW'(l_q); mb = MW'(ratio_q); end
			S_BEST1: begin ma = MW'(s_q); mb = MW'(bl_q); end
			S_BEST2: begin ma = MW'(bs_q); mb = MW'(l_q); end
			default: begin ma = '0; mb = '0; end
		endcase
	end

	assign in_ch.ready = (st_q == S_IDLE) && !out_v_q;
	assign out_ch.valid = out_v_q;
	assign out_ch.object_id = out_id_q;
	assign out_ch.is_new = out_new_q;
	assign out_ch.table_full = out_full_q;
	assign out_ch.object_age = out_age_q;

	logic keep;
	assign keep = vld_q[idx_q] && ((now_q - seen_mem[idx_q]) < TIME_BITS'(hold_q));

	// tables, written in clocked block
	always_ff @(posedge clk) begin
		if (st_q == S_APPLY) begin
			if (best_ok_q) begin
				box_mem[best_q] <= box_q;
				age_mem[best_q] <= age_mem[best_q] + now_q - seen_mem[best_q];
				seen_mem[best_q] <= now_q;
			end else if (used_q < CW'(MAX_OBJECTS)) begin
				box_mem[IW'(used_q)] <= box_q;
				age_mem[IW'(used_q)] <= '0;
				seen_mem[IW'(used_q)] <= now_q;
				id_mem[IW'(used_q)] <= next_id_q;
			end
		end else if (st_q == S_AGE && keep && wr_q != idx_q) begin
			box_mem[wr_q] <= box_mem[idx_q];
			age_mem[wr_q] <= age_mem[idx_q];
			seen_mem[wr_q] <= seen_mem[idx_q];
			id_mem[wr_q] <= id_mem[idx_q];
		end
	end

	// sequencer and registered result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			ratio_q <= RATIO_RESET;
			hold_q <= HOLD_RESET;
			vld_q <= '0;
			next_id_q <= '0;
			out_v_q <= 1'b0;
			now_q <= '0;
			box_q <= '0;
			fend_q <= 1'b0;
			barea_q <= '0;
			s_q <= '0;
			l_q <= '0;
			bs_q <= '0;
			bl_q <= '0;
			best_ok_q <= 1'b0;
			best_q <= '0;
			idx_q <= '0;
			wr_q <= '0;
			used_q <= '0;
			tmp_q <= '0;
			meet_q <= 1'b0;
			out_id_q <= '0;
			out_age_q <= '0;
			out_new_q <= 1'b0;
			out_full_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_MIN_RATIO: ratio_q <= cfg_data[RATIO_BITS-1:0];
					REG_HOLD: hold_q <= cfg_data[HOLD_BITS-1:0];
					default: ;
				endcase
			end
			if (out_v_q && out_ch.ready) out_v_q <= 1'b0;
			case (st_q)
				// take an item once the previous result has gone
				S_IDLE: begin
					if (in_ch.valid && !out_v_q) begin
						now_q <= in_ch.frame_time;
						box_q <= {in_ch.bottom_y, in_ch.right_x, in_ch.top_y, in_ch.left_x};
						fend_q <= in_ch.frame_end;
						idx_q <= '0;
						used_q <= '0;
						best_ok_q <= 1'b0;
						bs_q <= '0;
						bl_q <= AW'(1);
						st_q <= S_AREA;
					end
				end
				S_AREA: st_q <= S_SCAN;
				// valid entries form a prefix, the first empty one ends the scan
				S_SCAN: begin
					if (idx_q == '0) barea_q <= AW'(mp);
					if (vld_q[idx_q]) begin
						used_q <= used_q + CW'(1);
						meet_q <= (il < ir) && (it < ib);
						st_q <= S_OAREA;
					end else begin
						st_q <= S_APPLY;
					end
				end
				// smaller and larger area
				S_OAREA: begin
					if (barea_q < AW'(mp)) begin
						s_q <= barea_q;
						l_q <= AW'(mp);
					end else begin
						s_q <= AW'(mp);
						l_q <= barea_q;
					end
					st_q <= S_THR1;
				end
				S_THR1: st_q <= S_THR2;
				S_THR2: begin
					tmp_q <= mp;
					st_q <= S_BEST1;
				end
				// threshold: s*100 against l*pct
				S_BEST1: begin
					meet_q <= meet_q && (l_q != '0) && (tmp_q > mp);
					st_q <= S_BEST2;
				end
				S_BEST2: begin
					tmp_q <= mp;
					st_q <= S_DECIDE;
				end
				// best so far: s*bl against bs*l, earlier entry keeps ties
				S_DECIDE: begin
					if (meet_q && (!best_ok_q || tmp_q > mp)) begin
						best_ok_q <= 1'b1;
						best_q <= idx_q;
						bs_q <= s_q;
						bl_q <= l_q;
					end
					if (idx_q == IW'(MAX_OBJECTS-1)) begin
						st_q <= S_APPLY;
					end else begin
						idx_q <= idx_q + IW'(1);
						st_q <= S_SCAN;
					end
				end
				// match, insert or drop
				S_APPLY: begin
					if (best_ok_q) begin
						out_id_q <= id_mem[best_q];
						out_age_q <= age_mem[best_q] + now_q - seen_mem[best_q];
						out_new_q <= 1'b0;
						out_full_q <= 1'b0;
					end else if (used_q < CW'(MAX_OBJECTS)) begin
						vld_q[IW'(used_q)] <= 1'b1;
						out_id_q <= next_id_q;
						out_age_q <= '0;
						out_new_q <= 1'b1;
						out_full_q <= 1'b0;
						next_id_q <= next_id_q + ID_BITS'(1);
					end else begin
						out_id_q <= '0;
						out_age_q <= '0;
						out_new_q <= 1'b0;
						out_full_q <= 1'b1;
					end
					idx_q <= '0;
					wr_q <= '0;
					st_q <= fend_q ? S_AGE : S_OUT;
				end
				// frame-end compaction, one entry a cycle
				S_AGE: begin
					if (!keep || wr_q != idx_q) vld_q[idx_q] <= 1'b0;
					if (keep) begin
						vld_q[wr_q] <= 1'b1;
						wr_q <= wr_q + IW'(1);
					end
					if (idx_q == IW'(MAX_OBJECTS-1)) st_q <= S_OUT;
					else idx_q <= idx_q + IW'(1);
				end
				S_OUT: begin
					out_v_q <= 1'b1;
					st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end
endmodule

/* rtl/boxtrk_checker.sv */
`timescale 1ns / 1ps
module boxtrk_checker (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_ready,
	input logic out_valid,
	input logic out_ready,
	input logic is_new,
	input logic table_full,
	input logic [31:0] object_age
);
	// new and full never together
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(is_new && table_full)) else $error("new and full");
	// a new object has zero age
	a_age: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && is_new) |-> object_age == 32'd0) else $error("new age");
	// dropped box reports zero age
	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && table_full) |-> object_age == 32'd0) else $error("full age");
	// no acceptance right after another
	a_seq: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready) else $error("back to back");
	// a waiting result stays valid and keeps its age
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |=> out_valid && $stable(object_age))
		else $error("result dropped");
endmodule

bind bbox_overlap_object_tracker boxtrk_checker u_chk (
	.clk(clk), .arst_n(arst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready), .is_new(out_ch.is_new),
	.table_full(out_ch.table_full), .object_age(out_ch.object_age)
);
